[hw/rtl/sek_pkg.sv]
// shared types and codes for the stack edit engine
// used by sek_engine and stack_edit_engine_top; depends on nothing else
package sek_pkg;

  localparam int DEFAULT_STACK_DEPTH = 64;

  localparam int KIND_W   = 3;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SWAP   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] key;
    logic [POS_W-1:0]        position;
    logic [POS_W-1:0]        other_position;
  } req_t;

  typedef struct packed {
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } res_t;

  // top to engine
  typedef struct packed {
    logic start;
    logic res_ready;
  } sek_cmd_t;

  // engine to top
  typedef struct packed {
    logic idle;
    logic res_valid;
  } sek_sts_t;

endpackage

[hw/rtl/stack_edit_engine_top.sv]
// top level of the stack edit engine: stream ports, result register, key ram
// depends on sek_pkg, sek_engine and sek_ram
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready  in_tuser kind, in_tdata key/position/other_position
//   out_     out  out_tvalid/out_tready out_tdata found/status/count
//
// one request at a time; push and unused kinds finish at decode, swap reads both
// entries and writes them back, search scans the keys from the top down, insert
// and delete also shift keys, paced by the single read and single write port of the key ram.
// reset clears the entry count, not the keys; the key ram needs no clearing pass.
// a result waits in the output register while the next request is taken;
// the engine holds its next result until that register frees up.
module stack_edit_engine_top #(
  parameter int STACK_DEPTH = sek_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [47:0]                in_tdata,   // key[31:0], position[39:32], other_position[47:40]
  input  logic [sek_pkg::KIND_W-1:0] in_tuser,   // kind[2:0]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [15:0]                out_tdata   // found[0], status[2:1], count[9:3], zeros above
);
  import sek_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);

  sek_cmd_t cmd;
  sek_sts_t sts;
  req_t     req;
  res_t     res;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  logic out_tvalid_r, out_tvalid_nxt;
  res_t out_res_r, out_res_nxt;

  // unpack the input word
  always_comb begin
    req.kind           = in_tuser;
    req.key            = $signed(in_tdata[31:0]);
    req.position       = in_tdata[39:32];
    req.other_position = in_tdata[47:40];
  end

  // take a word only when the engine is free
  assign in_tready     = sts.idle;
  assign cmd.start     = in_tvalid & sts.idle;
  // the output register can load when empty or draining this cycle
  assign cmd.res_ready = ~out_tvalid_r | out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_res_nxt    = out_res_r;
    if (cmd.res_ready) begin
      out_tvalid_nxt = sts.res_valid;
      if (sts.res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, out_res_r.count, out_res_r.status, out_res_r.found};

  sek_engine #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .req       (req),
    .sts       (sts),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // key store: ordinal i lives at index i-1
  sek_ram #(
    .WIDTH(KEY_W),
    .DEPTH(STACK_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[hw/rtl/sek_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module sek_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/sek_engine.sv]
// sequencer for the stack edit engine: decodes a request, walks the key ram
// depends on sek_pkg; drives one sek_ram instance held by the top level
module sek_engine #(
  parameter int STACK_DEPTH = sek_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sek_pkg::sek_cmd_t              cmd,
  input  sek_pkg::req_t                  req,
  output sek_pkg::sek_sts_t              sts,
  output sek_pkg::res_t                  res,
  output logic                           ram_we,
  output logic [$clog2(STACK_DEPTH)-1:0] ram_waddr,
  output logic [sek_pkg::KEY_W-1:0]      ram_wdata,
  output logic [$clog2(STACK_DEPTH)-1:0] ram_raddr,
  input  logic [sek_pkg::KEY_W-1:0]      ram_rdata
);
  import sek_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN, S_DSHIFT, S_ISHIFT, S_ITOP,
    S_SWB, S_SWC, S_SWD, S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                found_r, found_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                end_r, end_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                rd_last_r, rd_last_nxt;
  req_t                req_r, req_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [AW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [KEY_W-1:0]    hold_r, hold_nxt;

  logic [PW-1:0] count_e, pos_e, pos2_e;
  logic [AW-1:0] top_idx, count_idx, pos_idx, pos2_idx;
  logic          full, match, pos_ok, pos2_ok;

  always_comb begin
    count_e   = PW'(count_r);
    pos_e     = PW'(req_r.position);
    pos2_e    = PW'(req_r.other_position);
    top_idx   = AW'(count_r - CW'(1));
    count_idx = AW'(count_r);
    pos_idx   = AW'(pos_e - PW'(1));
    pos2_idx  = AW'(pos2_e - PW'(1));
    full      = (count_r >= CW'(STACK_DEPTH));
    match     = (ram_rdata == $unsigned(req_r.key));
    pos_ok    = (pos_e != '0) && (pos_e <= count_e);
    pos2_ok   = (pos2_e != '0) && (pos2_e <= count_e);
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    found_nxt   = found_r;
    status_nxt  = status_r;
    end_nxt     = end_r;
    rd_vld_nxt  = 1'b0;
    rd_last_nxt = 1'b0;
    rd_idx_nxt  = ptr_r;
    req_nxt     = req_r;
    ptr_nxt     = ptr_r;
    hold_nxt    = hold_r;
    ram_we      = 1'b0;
    ram_waddr   = ptr_r;
    ram_wdata   = ram_rdata;
    ram_raddr   = ptr_r;
    sts.idle      = 1'b0;
    sts.res_valid = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        sts.idle = 1'b1;
        if (cmd.start) begin
          req_nxt    = req;
          found_nxt  = 1'b0;
          status_nxt = ST_OK;
          state_nxt  = S_DECODE;
        end
      end

      S_DECODE: begin
        ptr_nxt = top_idx;
        end_nxt = 1'b0;
        unique case (req_r.kind)
          KIND_PUSH: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_idx;
              ram_wdata = $unsigned(req_r.key);
              count_nxt = count_r + CW'(1);
            end
            state_nxt = S_DONE;
          end
          KIND_SEARCH, KIND_DELETE: begin
            if (count_r == '0) begin
              status_nxt = ST_NOT_FOUND;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          KIND_INSERT: begin
            if (pos_e == '0) begin
              status_nxt = ST_BAD_POS;
              state_nxt  = S_DONE;
            end else if (full) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else if (pos_e > count_e) begin
              // past the top: plain append
              ram_we    = 1'b1;
              ram_waddr = count_idx;
              ram_wdata = $unsigned(req_r.key);
              count_nxt = count_r + CW'(1);
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_ISHIFT;
            end
          end
          KIND_SWAP: begin
            if (!pos_ok || !pos2_ok || (pos_e == pos2_e)) begin
              status_nxt = ST_BAD_POS;
              state_nxt  = S_DONE;
            end else begin
              ram_raddr = pos_idx;
              state_nxt = S_SWB;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // walk from the top down, one read a cycle, stop at the first match
      S_SCAN: begin
        if (rd_vld_r && match) begin
          found_nxt = 1'b1;
          if (req_r.kind == KIND_SEARCH) begin
            state_nxt = S_DONE;
          end else if (rd_idx_r == top_idx) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_DONE;
          end else begin
            ptr_nxt   = rd_idx_r + AW'(1);
            end_nxt   = 1'b0;
            state_nxt = S_DSHIFT;
          end
        end else if (rd_vld_r && rd_last_r) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else if (!end_r) begin
          ram_raddr   = ptr_r;
          rd_vld_nxt  = 1'b1;
          rd_idx_nxt  = ptr_r;
          rd_last_nxt = (ptr_r == '0);
          end_nxt     = (ptr_r == '0);
          ptr_nxt     = ptr_r - AW'(1);
        end
      end

      // close the gap: read i, write i-1 in the cycle after
      S_DSHIFT: begin
        if (!end_r) begin
          ram_raddr   = ptr_r;
          rd_vld_nxt  = 1'b1;
          rd_idx_nxt  = ptr_r;
          rd_last_nxt = (ptr_r == top_idx);
          end_nxt     = (ptr_r == top_idx);
          ptr_nxt     = ptr_r + AW'(1);
        end
        if (rd_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_r - AW'(1);
          ram_wdata = ram_rdata;
          if (rd_last_r) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_DONE;
          end
        end
      end

      // open a gap: read j from the top down, write j+1 in the cycle after
      S_ISHIFT: begin
        if (!end_r) begin
          ram_raddr   = ptr_r;
          rd_vld_nxt  = 1'b1;
          rd_idx_nxt  = ptr_r;
          rd_last_nxt = (ptr_r == pos_idx);
          end_nxt     = (ptr_r == pos_idx);
          ptr_nxt     = ptr_r - AW'(1);
        end
        if (rd_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_r + AW'(1);
          ram_wdata = ram_rdata;
          if (rd_last_r) begin
            state_nxt = S_ITOP;
          end
        end
      end

      S_ITOP: begin
        ram_we    = 1'b1;
        ram_waddr = pos_idx;
        ram_wdata = $unsigned(req_r.key);
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end

      // first entry arrives, fetch the second
      S_SWB: begin
        hold_nxt  = ram_rdata;
        ram_raddr = pos2_idx;
        state_nxt = S_SWC;
      end

      S_SWC: begin
        ram_we    = 1'b1;
        ram_waddr = pos_idx;
        ram_wdata = ram_rdata;
        state_nxt = S_SWD;
      end

      S_SWD: begin
        ram_we    = 1'b1;
        ram_waddr = pos2_idx;
        ram_wdata = hold_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        sts.res_valid = 1'b1;
        if (cmd.res_ready) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      found_r   <= 1'b0;
      status_r  <= ST_OK;
      end_r     <= 1'b0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      found_r   <= found_nxt;
      status_r  <= status_nxt;
      end_r     <= end_nxt;
      rd_vld_r  <= rd_vld_nxt;
      rd_last_r <= rd_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    ptr_r    <= ptr_nxt;
    rd_idx_r <= rd_idx_nxt;
    hold_r   <= hold_nxt;
  end

  assign res.found  = found_r;
  assign res.status = status_r;
  assign res.count  = COUNT_W'(count_r);

endmodule
